[src/balm_pkg.sv]
// ----------------------------------------------------------------------------
// balm_pkg
// Shared types and constants for the band average level meter.
// ----------------------------------------------------------------------------
package balm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 13;
    localparam int BAND_W   = 3;
    localparam int LEVEL_W  = 7;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int SUM_W    = LEN_W + SAMPLE_W - 1;
    localparam int PROD_W   = MAG_W + LEVEL_W;

    localparam int PERCENT          = 100;
    localparam int FULL_SCALE_SHIFT = SAMPLE_W - 1;

    localparam int DEFAULT_BANDS         = 8;
    localparam int DEFAULT_MAX_FRAME_LEN = 4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [SUM_W-1:0]  sum;
        logic [LEN_W-1:0]  count;
        logic              last_band;
    } band_req_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_SCALE
    } back_state_t;

endpackage

[src/balm_front.sv]
// ----------------------------------------------------------------------------
// balm_front
// Sample intake: magnitude, band bookkeeping and band close requests.
// ----------------------------------------------------------------------------
module balm_front #(
    parameter int BANDS         = balm_pkg::DEFAULT_BANDS,
    parameter int MAX_FRAME_LEN = balm_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               accept,
    input  logic signed [balm_pkg::SAMPLE_W-1:0] sample,
    input  logic [balm_pkg::LEN_W-1:0]         frame_len,
    input  logic                               last_sample,
    output logic                               push,
    output balm_pkg::band_req_t                req
);

    localparam int LEN_W = balm_pkg::LEN_W;
    localparam int SUM_W = balm_pkg::SUM_W;
    localparam int MAG_W = balm_pkg::MAG_W;
    localparam int IDX_W = $clog2(BANDS + 1);
    localparam logic [LEN_W-1:0] BANDS_L = LEN_W'(BANDS);
    localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

    logic             enable_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] pos_reg, pos_next;

    logic [MAG_W-1:0] mag_ext;
    logic [MAG_W-1:0] mag;
    logic [LEN_W-1:0] len_nz;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] per_div;
    logic [LEN_W-1:0] per_band;
    logic [IDX_W-1:0] nbands;
    logic [SUM_W-1:0] sum_acc;
    logic [LEN_W-1:0] cnt_acc;
    logic             active;
    logic             close;

    always_comb
    begin
        mag_ext = {sample[balm_pkg::SAMPLE_W-1], sample};
        mag     = sample[balm_pkg::SAMPLE_W-1] ? (~mag_ext + MAG_W'(1)) : mag_ext;

        len_nz  = (frame_len == '0) ? LEN_W'(1) : frame_len;
        len_sat = (32'(len_nz) > 32'(MAX_FRAME_LEN)) ? LEN_W'(MAX_FRAME_LEN) : len_nz;
        per_div = len_sat / BANDS_L;

        if (per_div == '0)
        begin
            per_band = len_sat;
            nbands   = IDX_W'(1);
        end
        else
        begin
            per_band = per_div;
            nbands   = IDX_W'(BANDS);
        end

        active  = (pos_reg < len_sat) && (idx_reg < nbands);
        sum_acc = sum_reg + SUM_W'(mag);
        cnt_acc = cnt_reg + LEN_W'(1);
        close   = active && (cnt_acc >= per_band);

        push          = accept && enable_reg && close;
        req.band      = idx_reg[balm_pkg::BAND_W-1:0];
        req.sum       = sum_acc;
        req.count     = cnt_acc;
        req.last_band = ((idx_reg + IDX_W'(1)) == nbands);
    end

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            if (!enable_reg || last_sample)
            begin
                sum_next = '0;
                cnt_next = '0;
                idx_next = '0;
                pos_next = '0;
            end
            else
            begin
                if (close)
                begin
                    sum_next = '0;
                    cnt_next = '0;
                    idx_next = idx_reg + IDX_W'(1);
                end
                else if (active)
                begin
                    sum_next = sum_acc;
                    cnt_next = cnt_acc;
                end
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
        end
    end

endmodule

[src/balm_queue.sv]
// ----------------------------------------------------------------------------
// balm_queue
// Short request queue between the sample front and the division back.
// ----------------------------------------------------------------------------
module balm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  balm_pkg::band_req_t wr_req,
    input  logic                pop,
    output balm_pkg::band_req_t rd_req,
    output logic                full,
    output logic                empty
);

    localparam int QPTR_W = balm_pkg::QPTR_W;

    balm_pkg::band_req_t mem [balm_pkg::QUEUE_DEPTH];

    logic [QPTR_W:0] wptr_reg, wptr_next;
    logic [QPTR_W:0] rptr_reg, rptr_next;

    always_comb
    begin
        empty  = (wptr_reg == rptr_reg);
        full   = (wptr_reg[QPTR_W-1:0] == rptr_reg[QPTR_W-1:0]) &&
                 (wptr_reg[QPTR_W] != rptr_reg[QPTR_W]);
        rd_req = mem[rptr_reg[QPTR_W-1:0]];

        wptr_next = wptr_reg + (QPTR_W + 1)'(push && !full);
        rptr_next = rptr_reg + (QPTR_W + 1)'(pop && !empty);
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wptr_reg[QPTR_W-1:0]] <= wr_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

endmodule

[src/balm_back.sv]
// ----------------------------------------------------------------------------
// balm_back
// Band level: bit-serial sum/count division, percent scaling, output register.
// ----------------------------------------------------------------------------
module balm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  balm_pkg::band_req_t           req,
    input  logic                          req_avail,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [balm_pkg::BAND_W-1:0]   band,
    output logic [balm_pkg::LEVEL_W-1:0]  level,
    output logic                          last_band
);

    localparam int SUM_W  = balm_pkg::SUM_W;
    localparam int LEN_W  = balm_pkg::LEN_W;
    localparam int MAG_W  = balm_pkg::MAG_W;
    localparam int PROD_W = balm_pkg::PROD_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    balm_pkg::back_state_t state_reg, state_next;

    logic [SUM_W-1:0]            quo_reg;
    logic [LEN_W-1:0]            rem_reg;
    logic [LEN_W-1:0]            div_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [balm_pkg::BAND_W-1:0] band_reg;
    logic                        last_reg;

    logic                         out_valid_reg;
    logic [balm_pkg::BAND_W-1:0]  out_band_reg;
    logic [balm_pkg::LEVEL_W-1:0] out_level_reg;
    logic                         out_last_reg;

    logic             load_req;
    logic             div_step;
    logic             load_out;
    logic             out_free;
    logic [LEN_W:0]   trial;
    logic             trial_ge;
    logic [PROD_W-1:0] product;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            balm_pkg::BACK_IDLE:
            begin
                if (req_avail)
                begin
                    state_next = balm_pkg::BACK_DIV;
                end
            end
            balm_pkg::BACK_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = balm_pkg::BACK_SCALE;
                end
            end
            balm_pkg::BACK_SCALE:
            begin
                if (out_free)
                begin
                    state_next = balm_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = balm_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load_req = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            balm_pkg::BACK_IDLE:  load_req = req_avail;
            balm_pkg::BACK_DIV:   div_step = 1'b1;
            balm_pkg::BACK_SCALE: load_out = out_free;
            default:              load_req = 1'b0;
        endcase
    end

    assign pop = load_req;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge = (trial >= {1'b0, div_reg});
        product  = PROD_W'(quo_reg[MAG_W-1:0]) * PROD_W'(balm_pkg::PERCENT);
    end

    always_ff @(posedge clk)
    begin
        if (load_req)
        begin
            quo_reg  <= req.sum;
            rem_reg  <= '0;
            div_reg  <= req.count;
            band_reg <= req.band;
            last_reg <= req.last_band;
        end
        else if (div_step)
        begin
            rem_reg <= trial_ge ? LEN_W'(trial - {1'b0, div_reg}) : LEN_W'(trial);
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
        end
        if (load_out)
        begin
            out_band_reg  <= band_reg;
            out_level_reg <= product[balm_pkg::FULL_SCALE_SHIFT +: balm_pkg::LEVEL_W];
            out_last_reg  <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= balm_pkg::BACK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_req)
            begin
                step_reg <= '0;
            end
            else if (div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign band      = out_band_reg;
    assign level     = out_level_reg;
    assign last_band = out_last_reg;

endmodule

[src/band_average_level_meter.sv]
// ----------------------------------------------------------------------------
// band_average_level_meter
// Per-band mean magnitude of PCM frames, reported as percent of full scale.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one signed PCM sample per request, with
// the frame length and an end-of-frame mark. Samples are taken one per cycle
// while the band request queue has room.
// Output channel (out_valid/out_stall): one request per completed band with
// its index, level (0..100) and a flag on the final band of the frame.
// Configuration: cfg_we/cfg_wdata write the enable bit; with it clear,
// samples are accepted and dropped and the band state is cleared.
// The back end serves one band at a time: it takes no new request until the
// previous band has left its divide and scale states. The divider produces
// one quotient bit per cycle; the four-entry queue absorbs bursts, and
// in_stall rises when it fills.
// Reset clears the band state, the queue, the enable bit and out_valid.
// A stalled output holds its result; the divider finishes the next band and
// waits behind it.
// ----------------------------------------------------------------------------
module band_average_level_meter #(
    parameter int BANDS         = balm_pkg::DEFAULT_BANDS,
    parameter int MAX_FRAME_LEN = balm_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [balm_pkg::SAMPLE_W-1:0] sample,
    input  logic [balm_pkg::LEN_W-1:0]           frame_len,
    input  logic                                 last_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [balm_pkg::BAND_W-1:0]          band,
    output logic [balm_pkg::LEVEL_W-1:0]         level,
    output logic                                 last_band
);

    balm_pkg::band_req_t wr_req;
    balm_pkg::band_req_t rd_req;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    balm_front #(
        .BANDS         (BANDS),
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .sample      (sample),
        .frame_len   (frame_len),
        .last_sample (last_sample),
        .push        (q_push),
        .req         (wr_req)
    );

    balm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_req (wr_req),
        .pop    (q_pop),
        .rd_req (rd_req),
        .full   (q_full),
        .empty  (q_empty)
    );

    balm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (rd_req),
        .req_avail (!q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .band      (band),
        .level     (level),
        .last_band (last_band)
    );

endmodule

[src/balm_checker.sv]
// ----------------------------------------------------------------------------
// balm_checker
// Port-level properties of the band average level meter.
// ----------------------------------------------------------------------------
module balm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [balm_pkg::BAND_W-1:0]          band,
    input logic [balm_pkg::LEVEL_W-1:0]         level,
    input logic                                 last_band
);

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result request visible during reset");

    a_reset_ready: assert property (@(posedge clk)
        !rst_n |-> !in_stall)
        else $error("input stalled during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(band) && $stable(level)
                                   && $stable(last_band))
        else $error("stalled result request changed");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level <= balm_pkg::LEVEL_W'(balm_pkg::PERCENT))
        else $error("level above full scale");

endmodule

bind band_average_level_meter balm_checker u_checker (.*);
